// ----- rtl/sleep_timer_queue_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the sleep timer queue RTL.
// ----------------------------------------------------------------------------
`ifndef SLEEP_TIMER_QUEUE_CORE_ASSERT_SVH
`define SLEEP_TIMER_QUEUE_CORE_ASSERT_SVH

// Checked on every rising clock edge, held off while reset is asserted
`define STQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, including during reset
`define STQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg
// Sizes, result codes and controller/datapath interface types for the
// sleep timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    // Queue size and time width
    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 32;
    localparam int OCC_W     = $clog2(DEPTH + 1);
    localparam int ID_W      = 8;
    localparam int IN_TIME_W = 32;

    // Result codes
    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_WOKEN  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Input action codes
    localparam logic ACT_SLEEP = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic  capture;   // latch the input transfer
        logic  insert;    // insert the latched sleeper
        logic  pop;       // release the head entry
        logic  emit;      // load the output register
        kind_t kind;
        logic  last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic full;
        logic head_due;   // head entry wakes at or before the latched tick
        logic next_due;   // entry behind the head is also due
        logic out_free;   // output register can take a result this cycle
    } sts_t;

endpackage

// ----- rtl/stq_ctrl.sv -----
// ----------------------------------------------------------------------------
// stq_ctrl
// Controller: takes one item at a time and sequences insert, pop and
// result emission against the output register.
// ----------------------------------------------------------------------------
module stq_ctrl
    import stq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.kind    = KIND_ACCEPT;
        in_stall    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    if (!sts.is_tick)
                    begin
                        // sleep request: insert unless full
                        cmd.insert = !sts.full;
                        cmd.kind   = sts.full ? KIND_REJECT : KIND_ACCEPT;
                        state_next = ST_IDLE;
                    end
                    else if (sts.head_due)
                    begin
                        // release one id per cycle while the output register is free
                        cmd.pop  = 1'b1;
                        cmd.kind = KIND_WOKEN;
                        cmd.last = !sts.next_due;
                        if (!sts.next_due)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        // tick with nothing due
                        cmd.kind   = KIND_NONE;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/stq_datapath.sv -----
// ----------------------------------------------------------------------------
// stq_datapath
// Sorted shift-register queue of wake times and ids, the latched input
// item and the output result register.
// ----------------------------------------------------------------------------
`include "sleep_timer_queue_core_assert.svh"

module stq_datapath
    import stq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 action,
    input  logic [ID_W-1:0]      sleeper_id,
    input  logic [IN_TIME_W-1:0] wake_at,
    input  logic [IN_TIME_W-1:0] now_tick,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [ID_W-1:0]      woken_id,
    output logic                 last
);

    // Latched item
    logic                 act_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TIME_BITS-1:0] time_reg;

    // Queue entries, head at index 0
    logic [TIME_BITS-1:0] wake_reg   [DEPTH];
    logic [TIME_BITS-1:0] wake_next  [DEPTH];
    logic [ID_W-1:0]      thread_reg [DEPTH];
    logic [ID_W-1:0]      thread_next[DEPTH];
    logic [OCC_W-1:0]     occ_reg;

    // Output register
    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic                 out_last_reg;

    logic [DEPTH-1:0]     later;
    logic [DEPTH-1:0]     at_end;
    logic [DEPTH-1:0]     shift_in;

    // Valid entries waking strictly after the latched time, and the fill mark
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            later[i]  = (occ_reg > OCC_W'(i)) && (wake_reg[i] > time_reg);
            at_end[i] = (occ_reg == OCC_W'(i));
        end
    end

    assign shift_in = {later[DEPTH-2:0], 1'b0};

    // Status to the controller
    assign sts.is_tick  = (act_reg == ACT_TICK);
    assign sts.full     = (occ_reg == OCC_W'(DEPTH));
    assign sts.head_due = (occ_reg != '0) && (wake_reg[0] <= time_reg);
    assign sts.next_due = (occ_reg > OCC_W'(1)) && (wake_reg[1] <= time_reg);
    assign sts.out_free = !out_valid_reg || !out_stall;

    // Queue next state: insert shifts later entries back, pop shifts forward
    always_comb
    begin
        wake_next   = wake_reg;
        thread_next = thread_reg;
        if (cmd.insert)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (shift_in[i])
                begin
                    wake_next[i]   = wake_reg[(i + DEPTH - 1) % DEPTH];
                    thread_next[i] = thread_reg[(i + DEPTH - 1) % DEPTH];
                end
                else if (later[i] || at_end[i])
                begin
                    wake_next[i]   = time_reg;
                    thread_next[i] = id_reg;
                end
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                wake_next[i]   = wake_reg[i + 1];
                thread_next[i] = thread_reg[i + 1];
            end
        end
    end

    // Queue storage and latched item, no reset
    always_ff @(posedge clk)
    begin
        wake_reg   <= wake_next;
        thread_reg <= thread_next;
        if (cmd.capture)
        begin
            act_reg  <= action;
            id_reg   <= sleeper_id;
            time_reg <= (action == ACT_TICK) ? TIME_BITS'(now_tick) : TIME_BITS'(wake_at);
        end
    end

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.insert)
        begin
            occ_reg <= occ_reg + OCC_W'(1);
        end
        else if (cmd.pop)
        begin
            occ_reg <= occ_reg - OCC_W'(1);
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.kind;
            out_id_reg   <= cmd.pop ? thread_reg[0] : '0;
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign woken_id  = out_id_reg;
    assign last      = out_last_reg;

    // Checks
    `STQ_ASSERT(a_occ_bound, occ_reg <= OCC_W'(DEPTH), "occupancy above depth")
    `STQ_ASSERT(a_pop_nonempty, cmd.pop |-> (occ_reg != '0), "pop from empty queue")
    `STQ_ASSERT(a_insert_grows, cmd.insert |=> (occ_reg == $past(occ_reg) + OCC_W'(1)), "insert lost")
    `STQ_ASSERT(a_emit_slot, cmd.emit |-> (!out_valid_reg || !out_stall), "result overwritten")

endmodule

// ----- rtl/sleep_timer_queue_core.sv -----
// ----------------------------------------------------------------------------
// sleep_timer_queue_core
// Sorted queue of up to DEPTH sleeping thread ids ordered by wake time,
// ties kept first in, first out. Items are taken one at a time. A sleep
// request is latched at the transfer, then an insert compares all
// entries in parallel and shifts the later ones back; a full queue
// answers with a reject. A tick releases its due ids one at a time,
// since the shift-register queue pops one head entry per cycle while
// the result register is not stalled; each released id is its own
// result, the last one flagged, and a tick that wakes nothing gives one
// empty result. The next input transfer is taken as soon as the
// previous item has produced all of its results.
// ----------------------------------------------------------------------------
module sleep_timer_queue_core
    import stq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [ID_W-1:0]      sleeper_id,
    input  logic [IN_TIME_W-1:0] wake_at,
    input  logic [IN_TIME_W-1:0] now_tick,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [ID_W-1:0]      woken_id,
    output logic                 last
);

    cmd_t cmd;
    sts_t sts;

    // Controller
    stq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    stq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .action     (action),
        .sleeper_id (sleeper_id),
        .wake_at    (wake_at),
        .now_tick   (now_tick),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .woken_id   (woken_id),
        .last       (last)
    );

endmodule

// ----- verif/sleep_timer_queue_core_tb.sv -----
// ----------------------------------------------------------------------------
// sleep_timer_queue_core_tb
// Self-checking bench for the sleep timer queue. Sleep and tick transfers go
// in through the valid/stall input channel. A behavioral copy of the sorted
// queue predicts every result. A checker compares each output transfer,
// field by field, with the oldest prediction. Both channels idle at random
// in the first two of three phases.
// ----------------------------------------------------------------------------
module sleep_timer_queue_core_tb;
    import stq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One predicted output transfer
    typedef struct {
        kind_t           kind;
        logic [ID_W-1:0] id;
        logic            last;
    } wake_result_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic                 action     = ACT_SLEEP;
    logic [ID_W-1:0]      sleeper_id = '0;
    logic [IN_TIME_W-1:0] wake_at    = '0;
    logic [IN_TIME_W-1:0] now_tick   = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [1:0]           kind;
    logic [ID_W-1:0]      woken_id;
    logic                 last;

    // Predictor state: sorted by wake time, head at slot 0
    logic [TIME_BITS-1:0] sleep_wake [DEPTH];
    logic [ID_W-1:0]      sleep_thread [DEPTH];
    int                   sleep_count;

    wake_result_t         pending_results [$];

    int tx_idle_pct;
    int rx_stall_pct;
    int fail_count;
    int results_checked;
    int n_sleeps;
    int n_ticks;
    int n_rejects;
    int n_woken;
    int n_empty_ticks;
    int max_occupancy;
    int unsigned sim_clock;

    sleep_timer_queue_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .sleeper_id (sleeper_id),
        .wake_at    (wake_at),
        .now_tick   (now_tick),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .woken_id   (woken_id),
        .last       (last)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Check each output transfer against the oldest prediction; sampled at
    // the falling edge, the transfer itself completes at the next rising edge
    always @(negedge clk)
    begin : result_check
        wake_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d woken_id %0d last %0d",
                       kind, woken_id, last);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                results_checked++;
                if (kind !== exp_r.kind)
                begin
                    $error("kind: expected %0d, actual %0d", exp_r.kind, kind);
                    fail_count++;
                end
                if (woken_id !== exp_r.id)
                begin
                    $error("woken_id: expected %0d, actual %0d", exp_r.id, woken_id);
                    fail_count++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last: expected %0d, actual %0d", exp_r.last, last);
                    fail_count++;
                end
            end
        end
    end

    function automatic void push_result(kind_t k, logic [ID_W-1:0] id, logic lst);
        wake_result_t r;
        r.kind = k;
        r.id   = id;
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    // Update the sorted queue copy for one accepted transfer and queue the
    // results it must produce
    function automatic void predict_wakeups(logic act, logic [ID_W-1:0] id,
                                            logic [IN_TIME_W-1:0] wake,
                                            logic [IN_TIME_W-1:0] now);
        logic [TIME_BITS-1:0] t;
        int slot;
        int k;
        int n_due;
        if (act == ACT_SLEEP)
        begin
            n_sleeps++;
            t = TIME_BITS'(wake);
            if (sleep_count >= DEPTH)
            begin
                n_rejects++;
                push_result(KIND_REJECT, '0, 1'b1);
            end
            else
            begin
                // insert behind every entry due at or before t (ties FIFO)
                slot = 0;
                while (slot < sleep_count && sleep_wake[slot] <= t)
                    slot++;
                for (k = sleep_count; k > slot; k--)
                begin
                    sleep_wake[k]   = sleep_wake[k-1];
                    sleep_thread[k] = sleep_thread[k-1];
                end
                sleep_wake[slot]   = t;
                sleep_thread[slot] = id;
                sleep_count++;
                if (sleep_count > max_occupancy)
                    max_occupancy = sleep_count;
                push_result(KIND_ACCEPT, '0, 1'b1);
            end
        end
        else
        begin
            n_ticks++;
            t = TIME_BITS'(now);
            n_due = 0;
            while (n_due < sleep_count && sleep_wake[n_due] <= t)
                n_due++;
            if (n_due == 0)
            begin
                n_empty_ticks++;
                push_result(KIND_NONE, '0, 1'b1);
            end
            else
            begin
                for (k = 0; k < n_due; k++)
                    push_result(KIND_WOKEN, sleep_thread[k], (k + 1 == n_due));
                for (k = n_due; k < sleep_count; k++)
                begin
                    sleep_wake[k-n_due]   = sleep_wake[k];
                    sleep_thread[k-n_due] = sleep_thread[k];
                end
                sleep_count -= n_due;
                n_woken += n_due;
            end
        end
    endfunction

    // Drive one item, optionally after an idle gap, and wait for its transfer
    task automatic send_item(input logic act, input logic [ID_W-1:0] id,
                             input logic [IN_TIME_W-1:0] wake,
                             input logic [IN_TIME_W-1:0] now);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < tx_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        sleeper_id <= id;
        wake_at    <= wake;
        now_tick   <= now;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        predict_wakeups(act, id, wake, now);
    endtask

    task automatic sleep_item(input logic [ID_W-1:0] id, input logic [IN_TIME_W-1:0] wake);
        send_item(ACT_SLEEP, id, wake, IN_TIME_W'($urandom));
    endtask

    task automatic tick_item(input logic [IN_TIME_W-1:0] now);
        send_item(ACT_TICK, ID_W'($urandom), IN_TIME_W'($urandom), now);
    endtask

    // Hold the input side off until every predicted result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Empty-queue tick, extreme times, FIFO ties and a repeated id
    task automatic test_order_and_ties();
        tick_item('0);
        sleep_item(8'd0, '0);
        sleep_item(8'd255, '1);
        sleep_item(8'd7, 32'd5);
        sleep_item(8'd8, 32'd5);
        sleep_item(8'd7, 32'd5);
        tick_item(32'd4);
        tick_item(32'd5);
        tick_item(32'hFFFF_FFFE);
    endtask

    // Fill to capacity, check the reject, then release everything at once
    task automatic test_full_queue();
        int i;
        i = 0;
        while (sleep_count < DEPTH)
        begin
            // descending times land at the head, every third one ties
            sleep_item(ID_W'(8'hA5 ^ i), (i % 3 == 0) ? 32'd200 : 32'd200 - i * 7);
            i++;
        end
        sleep_item(8'h5A, 32'd1);
        tick_item('1);
    endtask

    // Mostly sleeps and ticks around a running clock, some random noise,
    // with a full drain halfway through
    task automatic test_random_traffic(input int n_items);
        int i;
        int r;
        logic [ID_W-1:0] id;
        for (i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                drain_results();
            r  = $urandom_range(0, 99);
            id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
            if (r < 8)
                sleep_item(id, IN_TIME_W'($urandom));
            else if (r < 12)
                tick_item(IN_TIME_W'($urandom));
            else if (r < 68)
                sleep_item(id, IN_TIME_W'(sim_clock + $urandom_range(0, 24)));
            else
            begin
                sim_clock += $urandom_range(0, 10);
                tick_item(IN_TIME_W'(sim_clock));
            end
        end
    endtask

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        sleep_count     = 0;
        fail_count      = 0;
        results_checked = 0;
        n_sleeps        = 0;
        n_ticks         = 0;
        n_rejects       = 0;
        n_woken         = 0;
        n_empty_ticks   = 0;
        max_occupancy   = 0;
        sim_clock       = 1000;
        tx_idle_pct     = 9;
        rx_stall_pct    = 52;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: light sender gaps, heavy receiver stalls
        test_order_and_ties();
        test_full_queue();
        test_random_traffic(60);
        drain_results();

        // phase 2: heavy sender gaps, light receiver stalls
        tx_idle_pct  = 52;
        rx_stall_pct = 9;
        test_random_traffic(60);
        drain_results();

        // phase 3: no idling on either side
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_random_traffic(60);
        drain_results();

        repeat (40) @(posedge clk);

        $display("covered %0d sleeps (%0d rejected), %0d ticks (%0d empty), %0d wakeups",
                 n_sleeps, n_rejects, n_ticks, n_empty_ticks, n_woken);
        $display("checked %0d results, peak occupancy %0d of %0d",
                 results_checked, max_occupancy, DEPTH);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
